### rtl/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
// Used by the controller, the datapath, the top level and the checker.
package lpg_pkg;

    // Default coordinate width
    localparam int LPG_COORD_BITS = 6;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture a new line request
        logic emit;   // move current pixel to output register and step
    } lpg_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last;   // current pixel is the end point
    } lpg_stat_t;

endpackage

### rtl/lpg_ctrl.sv
// Controller for the line pixel generator: request/run sequencing and output valid.
// Depends on lpg_pkg.
module lpg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lpg_pkg::lpg_cmd_t cmd,
    input  lpg_pkg::lpg_stat_t stat
);
    import lpg_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    // Output register can take a beat when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Commands and next state
    always_comb
    begin
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    if (stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

### rtl/lpg_dp.sv
// Datapath for the line pixel generator: deltas, error term, positions, output register.
// Depends on lpg_pkg.
module lpg_dp #(
    parameter int COORD_BITS = lpg_pkg::LPG_COORD_BITS
) (
    input  logic                  clk,
    input  logic [COORD_BITS-1:0] src_row,
    input  logic [COORD_BITS-1:0] src_col,
    input  logic [COORD_BITS-1:0] end_row,
    input  logic [COORD_BITS-1:0] end_col,
    input  lpg_pkg::lpg_cmd_t     cmd,
    output lpg_pkg::lpg_stat_t    stat,
    output logic [COORD_BITS-1:0] point_row,
    output logic [COORD_BITS-1:0] point_col,
    output logic                  last_point
);
    import lpg_pkg::*;

    // Error term needs sign plus twice the largest delta plus headroom
    localparam int EW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] d_row;
    logic [COORD_BITS-1:0] d_col;
    logic                  steep;
    logic [COORD_BITS-1:0] d_maj;
    logic [COORD_BITS-1:0] d_min;
    logic [EW-1:0]         err_init;

    logic [COORD_BITS-1:0] maj_pos_reg;
    logic [COORD_BITS-1:0] min_pos_reg;
    logic                  maj_up_reg;
    logic                  min_up_reg;
    logic                  steep_reg;
    logic [COORD_BITS-1:0] d_maj2_reg;
    logic [COORD_BITS-1:0] d_min2_reg;
    logic [EW-1:0]         err_reg;
    logic [COORD_BITS-1:0] remain_reg;
    logic [COORD_BITS-1:0] end_row_reg;
    logic [COORD_BITS-1:0] end_col_reg;
    logic [COORD_BITS-1:0] point_row_reg;
    logic [COORD_BITS-1:0] point_col_reg;
    logic                  last_point_reg;

    logic [EW-1:0]         d_maj2_x;
    logic [EW-1:0]         d_min2_x;
    logic                  err_nonneg;
    logic [EW-1:0]         err_next;
    logic [COORD_BITS-1:0] maj_pos_next;
    logic [COORD_BITS-1:0] min_pos_next;
    logic [COORD_BITS-1:0] cur_row;
    logic [COORD_BITS-1:0] cur_col;

    // Setup: absolute deltas, axis choice, initial error
    always_comb
    begin
        d_row    = (end_row >= src_row) ? (end_row - src_row) : (src_row - end_row);
        d_col    = (end_col >= src_col) ? (end_col - src_col) : (src_col - end_col);
        steep    = d_row > d_col;
        d_maj    = steep ? d_row : d_col;
        d_min    = steep ? d_col : d_row;
        err_init = {{2{1'b0}}, d_min, 1'b0} - {{3{1'b0}}, d_maj};
    end

    // Step: error update and position advance
    always_comb
    begin
        d_maj2_x     = {{2{1'b0}}, d_maj2_reg, 1'b0};
        d_min2_x     = {{2{1'b0}}, d_min2_reg, 1'b0};
        err_nonneg   = !err_reg[EW-1];
        err_next     = err_reg + d_min2_x - (err_nonneg ? d_maj2_x : {EW{1'b0}});
        maj_pos_next = maj_up_reg ? (maj_pos_reg + 1'b1) : (maj_pos_reg - 1'b1);
        if (err_nonneg)
        begin
            min_pos_next = min_up_reg ? (min_pos_reg + 1'b1) : (min_pos_reg - 1'b1);
        end
        else
        begin
            min_pos_next = min_pos_reg;
        end
        // end point forced exactly on the final pixel
        if (stat.last)
        begin
            cur_row = end_row_reg;
            cur_col = end_col_reg;
        end
        else
        begin
            cur_row = steep_reg ? maj_pos_reg : min_pos_reg;
            cur_col = steep_reg ? min_pos_reg : maj_pos_reg;
        end
    end

    assign stat.last = (remain_reg == '0);

    // Line state and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            steep_reg   <= steep;
            maj_pos_reg <= steep ? src_row : src_col;
            min_pos_reg <= steep ? src_col : src_row;
            maj_up_reg  <= steep ? (end_row > src_row) : (end_col > src_col);
            min_up_reg  <= steep ? (end_col > src_col) : (end_row > src_row);
            d_maj2_reg  <= d_maj;
            d_min2_reg  <= d_min;
            err_reg     <= err_init;
            remain_reg  <= d_maj;
            end_row_reg <= end_row;
            end_col_reg <= end_col;
        end
        else if (cmd.emit)
        begin
            maj_pos_reg <= maj_pos_next;
            min_pos_reg <= min_pos_next;
            err_reg     <= err_next;
            remain_reg  <= remain_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            point_row_reg  <= cur_row;
            point_col_reg  <= cur_col;
            last_point_reg <= stat.last;
        end
    end

    assign point_row  = point_row_reg;
    assign point_col  = point_col_reg;
    assign last_point = last_point_reg;

endmodule

### rtl/line_pixel_generator.sv
// Line pixel generator: Bresenham rasteriser, one pixel beat per cycle while m_tready is high.
// Depends on lpg_pkg, lpg_ctrl and lpg_dp.
//
// Usage:
//  - Slave channel (s_*) takes one line request per beat: start and end
//    row/column. s_tready is high only while no line is being walked.
//  - Master channel (m_*) gives one beat per pixel from start to end;
//    m_tlast marks the end point. A line gives max(|drow|,|dcol|)+1 beats.
//  - A request is registered in the line state, and each pixel in the output register.
//  - Throughput: one pixel per cycle while m_tready is high, set by the
//    single error-term step in the datapath; a request gives at most
//    2^COORD_BITS pixels.
//  - The next request is taken while the end point still sits in the
//    output register.
//  - A low m_tready holds the output register and the line walk; nothing
//    is lost.
//  - rst_n (asynchronous, active low) returns the controller to idle and
//    drops m_tvalid; a request in flight is discarded.
module line_pixel_generator #(
    parameter int COORD_BITS = lpg_pkg::LPG_COORD_BITS,
    localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // src_row, src_col, end_row, end_col
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // point_row, point_col, zero pad
    output logic             m_tlast    // last_point
);
    import lpg_pkg::*;

    lpg_cmd_t              cmd;
    lpg_stat_t             stat;
    logic [COORD_BITS-1:0] point_row;
    logic [COORD_BITS-1:0] point_col;

    lpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lpg_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .src_row    (s_tdata[COORD_BITS-1:0]),
        .src_col    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_row    (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_col    (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .cmd        (cmd),
        .stat       (stat),
        .point_row  (point_row),
        .point_col  (point_col),
        .last_point (m_tlast)
    );

    // Pack output beat, zero pad above
    assign m_tdata = {{(OUT_W - 2 * COORD_BITS){1'b0}}, point_col, point_row};

endmodule

### rtl/lpg_checker.sv
// Port-level checker for the line pixel generator, bound to the top level.
// Depends on lpg_pkg and line_pixel_generator.
module lpg_checker #(
    parameter int COORD_BITS = lpg_pkg::LPG_COORD_BITS,
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);
    import lpg_pkg::*;

    // Stalled beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // Stalled beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // A request beat makes the block busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a line is in progress");

    // A pixel short of the end point is always followed by another one
    a_line_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("line stopped before its end point");

    // Pad bits above the pixel stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >> (2 * COORD_BITS)) == '0)
        else $error("pad bits of output beat not zero");

endmodule

bind line_pixel_generator lpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_lpg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### test/tb.sv
// Testbench for line_pixel_generator: directed and random line requests with
// pixel-by-pixel checking against a Bresenham predictor. Needs lpg_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    import lpg_pkg::*;

    localparam int CB    = LPG_COORD_BITS;
    localparam int IN_W  = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CB + 7) / 8) * 8;

    typedef logic [CB-1:0] coord_t;

    localparam coord_t COORD_MAX = '1;

    typedef struct {
        coord_t row;
        coord_t col;
        logic   last_pt;
    } pixel_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;    // src_row, src_col, end_row, end_col
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // point_row, point_col, zero pad
    logic             m_tlast;         // last_point

    pixel_t pixel_queue[$];
    int     error_count = 0;
    int     sender_idle_pct = 0;
    int     receiver_stall_pct = 0;

    line_pixel_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Walk the line as the rasteriser should and queue every pixel
    function automatic void rasterise_line(input coord_t r0, input coord_t c0,
                                           input coord_t r1, input coord_t c1);
        int     d_row, d_col, s_row, s_col;
        int     maj_pos, min_pos, d_maj, d_min, s_maj, s_min, err;
        bit     steep;
        pixel_t px;
        d_row = int'(r1) - int'(r0);
        d_col = int'(c1) - int'(c0);
        s_row = (d_row > 0) ? 1 : -1;
        s_col = (d_col > 0) ? 1 : -1;
        if (d_row < 0) d_row = -d_row;
        if (d_col < 0) d_col = -d_col;
        // ties go to the column axis
        steep   = d_row > d_col;
        maj_pos = steep ? int'(r0) : int'(c0);
        min_pos = steep ? int'(c0) : int'(r0);
        d_maj   = steep ? d_row : d_col;
        d_min   = steep ? d_col : d_row;
        s_maj   = steep ? s_row : s_col;
        s_min   = steep ? s_col : s_row;
        err     = 2 * d_min - d_maj;
        for (int i = 0; i < d_maj; i++)
        begin
            px.row     = coord_t'(steep ? maj_pos : min_pos);
            px.col     = coord_t'(steep ? min_pos : maj_pos);
            px.last_pt = 1'b0;
            pixel_queue.push_back(px);
            if (err >= 0)
            begin
                min_pos += s_min;
                err     -= 2 * d_maj;
            end
            maj_pos += s_maj;
            err     += 2 * d_min;
        end
        // end point is always exact
        px.row     = r1;
        px.col     = c1;
        px.last_pt = 1'b1;
        pixel_queue.push_back(px);
    endfunction

    // Offer one request beat, with optional idle cycles ahead of it
    task automatic send_line(input coord_t r0, input coord_t c0,
                             input coord_t r1, input coord_t c1);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({c1, r1, c0, r0});
        do
            @(posedge clk);
        while (!s_tready);
        rasterise_line(r0, c0, r1, c1);
    endtask

    // Mostly uniform lines, some short ones around a random point
    task automatic send_random_line();
        coord_t r0, c0, r1, c1;
        r0 = coord_t'($urandom);
        c0 = coord_t'($urandom);
        if ($urandom_range(3) == 0)
        begin
            r1 = r0 + coord_t'($urandom_range(6)) - coord_t'(3);
            c1 = c0 + coord_t'($urandom_range(6)) - coord_t'(3);
        end
        else
        begin
            r1 = coord_t'($urandom);
            c1 = coord_t'($urandom);
        end
        send_line(r0, c0, r1, c1);
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // Pixel beat checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_queue.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected pixel beat row=%0d col=%0d last=%0b", $time,
                         m_tdata[CB-1:0], m_tdata[2*CB-1:CB], m_tlast);
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (m_tdata[CB-1:0] !== want.row)
                begin
                    error_count++;
                    $display("%0t: point_row expected %0d actual %0d", $time,
                             want.row, m_tdata[CB-1:0]);
                end
                if (m_tdata[2*CB-1:CB] !== want.col)
                begin
                    error_count++;
                    $display("%0t: point_col expected %0d actual %0d", $time,
                             want.col, m_tdata[2*CB-1:CB]);
                end
                if (m_tlast !== want.last_pt)
                begin
                    error_count++;
                    $display("%0t: last_point expected %0b actual %0b", $time,
                             want.last_pt, m_tlast);
                end
            end
        end
    end

    // Corners, edges, both diagonals, zero length, and steep and shallow lines in several directions
    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_line(0, 0, 0, 0);
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_line(21, 42, 21, 42);
        send_line(0, 0, 0, COORD_MAX);
        send_line(0, COORD_MAX, 0, 0);
        send_line(0, 0, COORD_MAX, 0);
        send_line(COORD_MAX, 5, 0, 5);
        send_line(0, 0, COORD_MAX, COORD_MAX);
        send_line(COORD_MAX, 0, 0, COORD_MAX);
        send_line(0, COORD_MAX, COORD_MAX, 0);
        send_line(COORD_MAX, COORD_MAX, 0, 0);
        send_line(10, 0, 20, COORD_MAX);
        send_line(20, COORD_MAX, 10, 0);
        send_line(0, 10, COORD_MAX, 20);
        send_line(COORD_MAX, 20, 0, 10);
        send_line(30, 40, 33, 10);
        send_line(40, 30, 10, 33);
        send_line(5, 5, 6, 6);
        send_line(5, 5, 6, 7);
        send_line(5, 5, 7, 6);
        send_line(42, 21, 21, 42);
        send_line(1, 62, 62, 1);
    endtask

    task automatic test_no_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (90) send_random_line();
    endtask

    task automatic test_sender_idle();
        sender_idle_pct    = 87;
        receiver_stall_pct = 0;
        repeat (90) send_random_line();
    endtask

    task automatic test_receiver_stall();
        sender_idle_pct    = 0;
        receiver_stall_pct = 87;
        repeat (90) send_random_line();
    endtask

    task automatic test_both_idle();
        sender_idle_pct    = 10;
        receiver_stall_pct = 10;
        repeat (90) send_random_line();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        s_tvalid <= 1'b0;
        // drain, then watch for stray beats
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
